FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by circular_queue
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define CQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// checked on every rising edge, reset included
`define CQ_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/cq_pkg.sv
// ----------------------------------------------------------------------------
// cq_pkg
// types, constants and pointer helpers of the circular queue
// ----------------------------------------------------------------------------
`default_nettype none

package cq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ITEM_W     = 32;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CNT_EXT_W  = PTR_W + COUNT_W;

  typedef logic [PTR_W-1:0]      ptr_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    REQ_ENQ  = 2'd0,
    REQ_DEQ  = 2'd1,
    REQ_CLR  = 2'd2,
    REQ_TRAV = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_e;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic ptr_t ring_count(ptr_t head, ptr_t tail);
    logic [PTR_W:0] c;
    if (tail >= head) begin
      c = {1'b0, tail} - {1'b0, head};
    end else begin
      c = {1'b0, tail} + (PTR_W+1)'(DEPTH) - {1'b0, head};
    end
    return c[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/circular_queue.sv
// ----------------------------------------------------------------------------
// circular_queue
// ring buffer fifo of words with one slot kept empty
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Enqueue, dequeue
// and clear give one result in the cycle after the request and do not raise
// busy, so they run back to back. Traverse gives one result per stored word
// (one when empty), one per cycle from the single read port of the word
// store, and holds busy high until its last read is issued. Results appear
// for exactly one cycle with done_o high and cannot be held off, so the
// receiver must take every one as it comes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module circular_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic signed [cq_pkg::VALUE_W-1:0] value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [cq_pkg::ITEM_W-1:0]  item_o,
  output logic                              item_valid_o,
  output logic                              last_o,
  output logic [cq_pkg::COUNT_W-1:0]        count_o,
  output logic                              is_empty_o
);
  import cq_pkg::*;

  state_e  state_q, state_d;
  ptr_t    head_q, head_d;
  ptr_t    tail_q, tail_d;
  ptr_t    trav_q, trav_d;

  logic    done_q, done_d;
  status_e status_q, status_d;
  logic    sel_q, sel_d;
  logic    last_q, last_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic    empty_q, empty_d;

  logic    ram_we, ram_re;
  ptr_t    ram_raddr;
  word_t   ram_wdata, ram_rdata;

  logic    accept;
  req_e    req;
  ptr_t    head_nx, tail_nx, trav_nx;
  logic    q_empty, q_full;

  assign busy    = (state_q == S_TRAV);
  assign accept  = start && !busy;
  assign req     = req_e'(req_type_i);
  assign head_nx = ring_next(head_q);
  assign tail_nx = ring_next(tail_q);
  assign trav_nx = ring_next(trav_q);
  assign q_empty = (head_q == tail_q);
  assign q_full  = (tail_nx == head_q);

  assign ram_wdata = WORD_WIDTH'({{WORD_WIDTH{1'b0}}, value_i});

  cq_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && req == REQ_TRAV && !q_empty && head_nx != tail_q) begin
          state_d = S_TRAV;
        end
      end
      S_TRAV: begin
        if (trav_nx == tail_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // pointer, memory and result control
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    trav_d    = trav_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    done_d    = 1'b0;
    status_d  = ST_DONE;
    sel_d     = 1'b0;
    last_d    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d = 1'b1;
          unique case (req)
            REQ_ENQ: begin
              if (q_full) begin
                status_d = ST_FULL;
              end else begin
                ram_we = 1'b1;
                tail_d = tail_nx;
              end
            end
            REQ_DEQ: begin
              if (q_empty) begin
                status_d = ST_EMPTY;
              end else begin
                ram_re = 1'b1;
                sel_d  = 1'b1;
                head_d = head_nx;
              end
            end
            REQ_CLR: begin
              head_d = '0;
              tail_d = '0;
            end
            REQ_TRAV: begin
              if (!q_empty) begin
                ram_re = 1'b1;
                sel_d  = 1'b1;
                last_d = (head_nx == tail_q);
                trav_d = head_nx;
              end
            end
            default: ;
          endcase
        end
      end
      S_TRAV: begin
        ram_re    = 1'b1;
        ram_raddr = trav_q;
        done_d    = 1'b1;
        sel_d     = 1'b1;
        last_d    = (trav_nx == tail_q);
        trav_d    = trav_nx;
      end
      default: ;
    endcase
    count_d = COUNT_W'({{COUNT_W{1'b0}}, ring_count(head_d, tail_d)});
    empty_d = (head_d == tail_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    trav_q   <= trav_d;
    status_q <= status_d;
    sel_q    <= sel_d;
    last_q   <= last_d;
    count_q  <= count_d;
    empty_q  <= empty_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign item_valid_o = sel_q;
  assign item_o       = sel_q ? ITEM_W'({{ITEM_W{1'b0}}, ram_rdata}) : '0;
  assign last_o       = last_q;
  assign count_o      = count_q;
  assign is_empty_o   = empty_q;

  `CQ_ASSERT(a_trav_emits, busy |=> done_q && sel_q)
  `CQ_ASSERT(a_single_result, accept && req != REQ_TRAV |=> done_q && last_q)
  `CQ_ASSERT(a_item_ok, done_q && sel_q |-> status_q == ST_DONE)
  `CQ_ASSERT(a_ptr_range, head_q <= PTR_W'(DEPTH - 1) && tail_q <= PTR_W'(DEPTH - 1))
  `CQ_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !done_q && !busy)

endmodule

`default_nettype wire

FILE: hw/rtl/cq_ram.sv
// ----------------------------------------------------------------------------
// cq_ram
// word store of the queue, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cq_ram (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire cq_pkg::ptr_t  waddr_i,
  input  wire cq_pkg::word_t wdata_i,
  input  wire logic          re_i,
  input  wire cq_pkg::ptr_t  raddr_i,
  output cq_pkg::word_t      rdata_o
);
  import cq_pkg::*;

  word_t mem_q [DEPTH];
  word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the circular queue
// ----------------------------------------------------------------------------
// Requests come from a backlog filled at time zero. The backlog starts with a
// directed run: empty traverse and dequeue, extreme words, filling to full, a
// refused enqueue, a full traverse and a clear. A random run follows, in
// chunks that lean toward filling, draining or neither. A shadow ring buffer
// predicts every result of each accepted request. The monitor checks each
// done_o cycle against the oldest prediction, field by field. The sender idles
// at a rate set for each chunk, and now and then waits for the queue of
// predictions to empty before it sends the next request.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_CHUNKS    = 10;
  localparam int unsigned CHUNK_LEN   = 38;

  typedef enum int {
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_NONE
  } lean_e;

  typedef struct {
    req_e  kind;
    word_t value;
    int    idle_pct;
    bit    hold;
  } request_t;

  typedef struct {
    status_e            status;
    word_t              item;
    logic               item_valid;
    logic               last;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } result_t;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  logic [1:0]         req_type_i = REQ_ENQ;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic               busy;
  logic               done_o;
  logic [1:0]         status_o;
  logic signed [ITEM_W-1:0] item_o;
  logic               item_valid_o;
  logic               last_o;
  logic [COUNT_W-1:0] count_o;
  logic               is_empty_o;

  request_t    req_backlog[$];
  result_t     pending_results[$];
  word_t       shadow_slots[DEPTH];
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;
  int unsigned fail_count  = 0;
  int unsigned cycle_cnt   = 0;
  int          gen_idle    = 0;
  bit          gen_hold    = 1'b0;

  circular_queue u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .item_o       (item_o),
    .item_valid_o (item_valid_o),
    .last_o       (last_o),
    .count_o      (count_o),
    .is_empty_o   (is_empty_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned step_ptr(int unsigned p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic void push_result(status_e status, word_t item, logic valid,
                                      logic last);
    result_t     r;
    int unsigned n;
    n = (shadow_tail + DEPTH - shadow_head) % DEPTH;
    r.status     = status;
    r.item       = item;
    r.item_valid = valid;
    r.last       = last;
    r.count      = COUNT_W'(n);
    r.is_empty   = (n == 0);
    pending_results.push_back(r);
  endfunction

  function automatic void predict_queue_results(req_e kind, word_t val);
    int unsigned p;
    int unsigned nx;
    case (kind)
      REQ_ENQ: begin
        if (step_ptr(shadow_tail) == shadow_head) begin
          push_result(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          shadow_slots[shadow_tail] = val;
          shadow_tail = step_ptr(shadow_tail);
          push_result(ST_DONE, '0, 1'b0, 1'b1);
        end
      end
      REQ_DEQ: begin
        if (shadow_head == shadow_tail) begin
          push_result(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          p = shadow_head;
          shadow_head = step_ptr(shadow_head);
          push_result(ST_DONE, shadow_slots[p], 1'b1, 1'b1);
        end
      end
      REQ_CLR: begin
        shadow_head = 0;
        shadow_tail = 0;
        push_result(ST_DONE, '0, 1'b0, 1'b1);
      end
      default: begin
        if (shadow_head == shadow_tail) begin
          push_result(ST_DONE, '0, 1'b0, 1'b1);
        end else begin
          p = shadow_head;
          while (p != shadow_tail) begin
            nx = step_ptr(p);
            push_result(ST_DONE, shadow_slots[p], 1'b1, nx == shadow_tail);
            p = nx;
          end
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic add_request(req_e kind, word_t value);
    request_t r;
    r.kind     = kind;
    r.value    = value;
    r.idle_pct = gen_idle;
    r.hold     = gen_hold;
    gen_hold   = 1'b0;
    req_backlog.push_back(r);
  endtask

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(15))
      0:       w = 32'h8000_0000;
      1:       w = 32'h7fff_ffff;
      2:       w = '0;
      3:       w = '1;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // driver: hold a request until accepted, then present the next one or idle
  always @(posedge clk_i) begin : driver_p
    request_t nxt;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_queue_results(req_e'(req_type_i), word_t'(value_i));
      end
      if (!start || !busy) begin
        if (req_backlog.size() > 0
            && !(req_backlog[0].hold && pending_results.size() != 0)
            && $urandom_range(99) >= req_backlog[0].idle_pct) begin
          nxt = req_backlog.pop_front();
          start      <= 1'b1;
          req_type_i <= nxt.kind;
          value_i    <= nxt.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done_o cycle is one result transaction
  always @(posedge clk_i) begin : monitor_p
    result_t e;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result item", item_o, '0);
      end else begin
        e = pending_results.pop_front();
        if (status_o !== e.status) report_mismatch("status", status_o, e.status);
        if (item_o !== e.item) report_mismatch("item", item_o, e.item);
        if (item_valid_o !== e.item_valid)
          report_mismatch("item_valid", item_valid_o, e.item_valid);
        if (last_o !== e.last) report_mismatch("last", last_o, e.last);
        if (count_o !== e.count) report_mismatch("count", count_o, e.count);
        if (is_empty_o !== e.is_empty) report_mismatch("is_empty", is_empty_o, e.is_empty);
      end
    end
  end

  initial begin : watchdog_p
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus_p
    lean_e lean;
    int    roll;
    req_e  kind;

    // directed run
    add_request(REQ_TRAV, '0);
    add_request(REQ_DEQ, '0);
    add_request(REQ_ENQ, 32'h8000_0000);
    add_request(REQ_ENQ, 32'h7fff_ffff);
    add_request(REQ_ENQ, '0);
    add_request(REQ_ENQ, '1);
    add_request(REQ_ENQ, 32'h5555_5555);
    add_request(REQ_ENQ, 32'haaaa_aaaa);
    for (int i = 0; i < DEPTH - 7; i++) add_request(REQ_ENQ, $urandom);
    add_request(REQ_ENQ, 32'h1234_5678);
    add_request(REQ_TRAV, '0);
    add_request(REQ_DEQ, '0);
    add_request(REQ_CLR, '0);
    add_request(REQ_TRAV, '0);
    add_request(REQ_DEQ, '0);

    // random run
    for (int c = 0; c < N_CHUNKS; c++) begin
      lean = lean_e'(c % 3);
      case (c % 4)
        0: gen_idle = 0;
        1: gen_idle = 45;
        2: gen_idle = 14;
        default: gen_idle = 0;
      endcase
      if (c == 0 || c == 5) gen_hold = 1'b1;
      for (int i = 0; i < CHUNK_LEN; i++) begin
        roll = $urandom_range(99);
        case (lean)
          LEAN_FILL: kind = (roll < 68) ? REQ_ENQ : (roll < 82) ? REQ_DEQ :
                            (roll < 96) ? REQ_TRAV : REQ_CLR;
          LEAN_DRAIN: kind = (roll < 20) ? REQ_ENQ : (roll < 80) ? REQ_DEQ :
                             (roll < 96) ? REQ_TRAV : REQ_CLR;
          default: kind = (roll < 42) ? REQ_ENQ : (roll < 82) ? REQ_DEQ :
                          (roll < 96) ? REQ_TRAV : REQ_CLR;
        endcase
        add_request(kind, (kind == REQ_ENQ || roll[0]) ? pick_word() : word_t'('0));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_backlog.size() != 0 || start) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cq_pkg.sv
hw/rtl/cq_ram.sv
hw/rtl/circular_queue.sv
dv/tb_top.sv
